// ===== sv/ght_pkg.sv =====
// ----------------------------------------------------------------------------
// ght_pkg
// shared types, sizes and codes of the generational handle table
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int GEN_BITS   = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic [CNT_W-1:0] SLOTS      = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] SLOTS_LAST = CNT_W'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    CMD_SPAWN  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAWN_SLOT,
    S_SPAWN_GEN,
    S_CHECK,
    S_MOVE
  } state_t;

  // one word of the slot memory: generation plus dense mapping
  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic                dead;
    logic [IDX_W-1:0]    pos;
  } slot_entry_t;

  localparam int SLOT_W = $bits(slot_entry_t);

  // generation bump, wrapping past zero to one
  function automatic logic [GEN_BITS-1:0] next_gen(input logic [GEN_BITS-1:0] g);
    logic [GEN_BITS-1:0] n;
    n = g + GEN_BITS'(1);
    if (n == '0) begin
      n = GEN_BITS'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/generational_handle_table.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table
// generational handle allocator with a packed dense array
// ----------------------------------------------------------------------------
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   request | req_valid | req_stall | cmd, handle_index, handle_generation
//   result  | rsp_valid | rsp_stall | status, out_index, out_generation,
//           |           |           | dense_position, move_needed, move_source,
//           |           |           | move_target, entity_count
//
// steps: lookup and remove go through the check step, and spawn through the
//   spawn slot step; spawn of a recycled slot adds the spawn gen step and remove
//   with a move adds the move step, for the dependent reads of the two memories
// reset: clears the sequencer, the three counters and the result valid; the
//   memories are not cleared and need no clearing pass
// stalls: one item at a time; a finished item waits in the result register
//   and the sequencer holds in each step after accept until that register has room
//
// storage
//   slot memory: per slot {generation, dead flag, dense position}
//   list memory: dense_to_slot grows up from address 0, the free stack grows
//     down from the top; live + free equals slots issued, so they never meet
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table
  import ght_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic [1:0]          cmd,
  input  wire logic [IDX_W-1:0]    handle_index,
  input  wire logic [GEN_BITS-1:0] handle_generation,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output logic [1:0]               status,
  output logic [IDX_W-1:0]         out_index,
  output logic [GEN_BITS-1:0]      out_generation,
  output logic [IDX_W-1:0]         dense_position,
  output logic                     move_needed,
  output logic [IDX_W-1:0]         move_source,
  output logic [IDX_W-1:0]         move_target,
  output logic [CNT_W-1:0]         entity_count
);

  // sequencer and counters
  state_t              state, state_next;
  logic [CNT_W-1:0]    free_count, free_count_next;
  logic [CNT_W-1:0]    slots_issued, slots_issued_next;
  logic [CNT_W-1:0]    live_count, live_count_next;

  // latched item and working registers
  logic [1:0]          cmd_q;
  logic [IDX_W-1:0]    idx_q;
  logic [GEN_BITS-1:0] gen_q;
  logic [IDX_W-1:0]    slot, slot_next;
  logic [IDX_W-1:0]    hole, hole_next;
  logic [IDX_W-1:0]    last, last_next;

  // memory ports
  logic                slot_re, slot_we;
  logic [IDX_W-1:0]    slot_raddr, slot_waddr;
  slot_entry_t         slot_rdata, slot_wdata, slot_wmask;
  logic                list_re, list_we;
  logic [IDX_W-1:0]    list_raddr, list_waddr;
  logic [IDX_W-1:0]    list_rdata, list_wdata;

  // result being loaded
  logic                rsp_load;
  status_t             r_status;
  logic [IDX_W-1:0]    r_index;
  logic [GEN_BITS-1:0] r_gen;
  logic [IDX_W-1:0]    r_pos;
  logic                r_move;
  logic [IDX_W-1:0]    r_src;
  logic [IDX_W-1:0]    r_tgt;
  logic [CNT_W-1:0]    r_count;

  logic                room;
  logic                handle_ok;
  logic [CNT_W-1:0]    pop_diff, push_diff, live_dec;
  logic [IDX_W-1:0]    pop_addr, push_addr, live_pos, new_slot;
  slot_entry_t         map_mask;

  ght_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .wmask (slot_wmask)
  );

  ght_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_list_ram (
    .clk   (clk),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .wmask ({IDX_W{1'b1}})
  );

  assign req_stall = (state != S_IDLE);
  assign room      = !rsp_valid || !rsp_stall;

  // free stack entry k lives at address SLOT_COUNT-1-k
  assign pop_diff  = SLOTS - free_count;
  assign pop_addr  = pop_diff[IDX_W-1:0];
  assign push_diff = SLOTS_LAST - free_count;
  assign push_addr = push_diff[IDX_W-1:0];
  assign live_dec  = live_count - CNT_W'(1);
  assign live_pos  = live_count[IDX_W-1:0];
  assign new_slot  = slots_issued[IDX_W-1:0];
  assign map_mask  = '{gen: '0, dead: 1'b1, pos: '1};

  // slot word read at accept stays in the read register until the check
  assign handle_ok = ({1'b0, idx_q} < slots_issued) && (slot_rdata.gen != '0)
                     && (slot_rdata.gen == gen_q) && !slot_rdata.dead;

  always_comb begin
    state_next        = state;
    free_count_next   = free_count;
    slots_issued_next = slots_issued;
    live_count_next   = live_count;
    slot_next         = slot;
    hole_next         = hole;
    last_next         = last;

    slot_re    = 1'b0;
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_wmask = '0;
    list_re    = 1'b0;
    list_raddr = '0;
    list_we    = 1'b0;
    list_waddr = '0;
    list_wdata = '0;

    rsp_load = 1'b0;
    r_status = ST_BAD;
    r_index  = '0;
    r_gen    = '0;
    r_pos    = '0;
    r_move   = 1'b0;
    r_src    = '0;
    r_tgt    = '0;
    r_count  = live_count;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          // read the handle's slot word and the free stack top up front
          slot_re    = 1'b1;
          slot_raddr = handle_index;
          list_re    = 1'b1;
          list_raddr = pop_addr;
          if (cmd == CMD_SPAWN) begin
            state_next = S_SPAWN_SLOT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end

      S_SPAWN_SLOT: begin
        if (room) begin
          if (free_count != '0) begin
            // recycled slot: fetch its generation
            slot_next  = list_rdata;
            slot_re    = 1'b1;
            slot_raddr = list_rdata;
            state_next = S_SPAWN_GEN;
          end else if (slots_issued != SLOTS) begin
            // fresh slot starts at generation one
            slot_we           = 1'b1;
            slot_waddr        = new_slot;
            slot_wdata        = '{gen: GEN_BITS'(1), dead: 1'b0, pos: live_pos};
            slot_wmask        = '1;
            list_we           = 1'b1;
            list_waddr        = live_pos;
            list_wdata        = new_slot;
            slots_issued_next = slots_issued + CNT_W'(1);
            live_count_next   = live_count + CNT_W'(1);
            rsp_load          = 1'b1;
            r_status          = ST_OK;
            r_index           = new_slot;
            r_gen             = GEN_BITS'(1);
            r_pos             = live_pos;
            r_count           = live_count + CNT_W'(1);
            state_next        = S_IDLE;
          end else begin
            rsp_load   = 1'b1;
            r_status   = ST_FULL;
            state_next = S_IDLE;
          end
        end
      end

      S_SPAWN_GEN: begin
        if (room) begin
          slot_we         = 1'b1;
          slot_waddr      = slot;
          slot_wdata      = '{gen: '0, dead: 1'b0, pos: live_pos};
          slot_wmask      = map_mask;
          list_we         = 1'b1;
          list_waddr      = live_pos;
          list_wdata      = slot;
          free_count_next = free_count - CNT_W'(1);
          live_count_next = live_count + CNT_W'(1);
          rsp_load        = 1'b1;
          r_status        = ST_OK;
          r_index         = slot;
          r_gen           = slot_rdata.gen;
          r_pos           = live_pos;
          r_count         = live_count + CNT_W'(1);
          state_next      = S_IDLE;
        end
      end

      S_CHECK: begin
        if (room) begin
          state_next = S_IDLE;
          case (cmd_q)
            CMD_LOOKUP: begin
              rsp_load = 1'b1;
              if (handle_ok) begin
                r_status = ST_OK;
                r_pos    = slot_rdata.pos;
              end
            end
            CMD_REMOVE: begin
              if (handle_ok && (live_count != '0)) begin
                // retire the slot and push it on the free stack
                slot_we         = 1'b1;
                slot_waddr      = idx_q;
                slot_wdata      = '{gen: next_gen(slot_rdata.gen), dead: 1'b1, pos: '0};
                slot_wmask      = '1;
                list_we         = 1'b1;
                list_waddr      = push_addr;
                list_wdata      = idx_q;
                free_count_next = free_count + CNT_W'(1);
                live_count_next = live_dec;
                if (slot_rdata.pos != live_dec[IDX_W-1:0]) begin
                  // hole is not the tail: fetch the tail's slot to move it
                  list_re    = 1'b1;
                  list_raddr = live_dec[IDX_W-1:0];
                  hole_next  = slot_rdata.pos;
                  last_next  = live_dec[IDX_W-1:0];
                  state_next = S_MOVE;
                end else begin
                  rsp_load = 1'b1;
                  r_status = ST_OK;
                  r_count  = live_dec;
                end
              end else begin
                rsp_load = 1'b1;
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end

      S_MOVE: begin
        if (room) begin
          // tail entry takes over the hole
          list_we    = 1'b1;
          list_waddr = hole;
          list_wdata = list_rdata;
          slot_we    = 1'b1;
          slot_waddr = list_rdata;
          slot_wdata = '{gen: '0, dead: 1'b0, pos: hole};
          slot_wmask = map_mask;
          rsp_load   = 1'b1;
          r_status   = ST_OK;
          r_move     = 1'b1;
          r_src      = last;
          r_tgt      = hole;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_count   <= '0;
      slots_issued <= '0;
      live_count   <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      free_count   <= free_count_next;
      slots_issued <= slots_issued_next;
      live_count   <= live_count_next;
      rsp_valid    <= rsp_load || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req_valid) begin
      cmd_q <= cmd;
      idx_q <= handle_index;
      gen_q <= handle_generation;
    end
    slot <= slot_next;
    hole <= hole_next;
    last <= last_next;
    if (rsp_load) begin
      status         <= r_status;
      out_index      <= r_index;
      out_generation <= r_gen;
      dense_position <= r_pos;
      move_needed    <= r_move;
      move_source    <= r_src;
      move_target    <= r_tgt;
      entity_count   <= r_count;
    end
  end

  // every issued slot is either live or on the free stack
  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, free_count} + {1'b0, live_count}) == {1'b0, slots_issued})
    else $error("live plus free count differs from slots issued");

  a_issued_bound: assert property (@(posedge clk) disable iff (rst)
    slots_issued <= SLOTS)
    else $error("more slots issued than the table holds");

  // a stalled result stays valid and keeps its status, dense position and count
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status)
                                  && $stable(dense_position) && $stable(entity_count)))
    else $error("stalled result item changed");

  a_move_distinct: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && move_needed) |-> (move_source != move_target))
    else $error("move reported onto its own position");

endmodule

`default_nettype wire

// ===== sv/ght_ram.sv =====
// ----------------------------------------------------------------------------
// ght_ram
// simple dual-port ram, bit write mask, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [WIDTH-1:0]         wmask
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask[b]) begin
          mem[waddr][b] <= wdata[b];
        end
      end
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
